@@ rtl/core/kufe_pkg.sv @@
// Package: shared types and constants for the union-find spanning tree engine.
package kufe_pkg;

  localparam int MaxNodes = 1024;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int CountW = NodeW + 1;
  localparam int LenW = 34;
  localparam int SqW = 31;
  localparam int RadW = SqW + 16 + 1;
  localparam int RootW = 24;
  localparam logic [CountW-1:0] NodeCountReset = CountW'(MaxNodes);

  typedef struct packed {
    logic            first_edge;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [SqW-1:0]  squared_length;
  } in_word_t;

  typedef struct packed {
    logic              accepted;
    logic [CountW-1:0] components_left;
    logic [LenW-1:0]   total_length;
    logic              finished;
  } out_word_t;

  // classified command from front to back
  typedef struct packed {
    logic              clear;
    logic [NodeW-1:0]  node_a;
    logic [NodeW-1:0]  node_b;
    logic              a_ok;
    logic              b_ok;
    logic [CountW-1:0] n_eff;
    logic [SqW-1:0]    sq;
  } cmd_t;

endpackage

@@ rtl/core/kruskal_union_find_engine.sv @@
// Top level: union-find spanning tree engine with running tree length.
//
//   channel  direction  handshake                 word
//   in_      input      in_valid / in_ready       in_word_t
//   out_     output     out_valid / out_ready     out_word_t
//   cfg_     input      cfg_we (no wait)          node_count
//
// An in-range edge walks to both roots, compressing the paths, and runs the
// bit-pair square root when it is accepted; an edge skipped outright does
// neither. The registered read of the parent table sets the walk pace.
// A first_edge adds a sweep over the whole parent table.
// After reset a clearing pass over the whole table runs before edges are taken.
// A two-entry queue decouples intake from the back end.
module kruskal_union_find_engine
  import kufe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data
);

  logic [CountW-1:0] node_count_r;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= NodeCountReset;
    else if (cfg_we) node_count_r <= cfg_wdata;
  end

  kufe_front u_front (
    .clk(clk), .rst_n(rst_n), .node_count(node_count_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  kufe_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

@@ rtl/core/kufe_front.sv @@
// Front end: clamps the node count, range-checks endpoints and queues commands.
module kufe_front
  import kufe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CountW-1:0] node_count,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic [CountW-1:0] n_eff;
  cmd_t c;
  logic push, pop;

  always_comb begin
    n_eff = node_count;
    if (node_count < CountW'(2)) n_eff = CountW'(2);
    if (node_count > CountW'(MaxNodes)) n_eff = CountW'(MaxNodes);
    c.clear = in_data.first_edge;
    c.node_a = in_data.node_a;
    c.node_b = in_data.node_b;
    c.a_ok = {1'b0, in_data.node_a} < n_eff;
    c.b_ok = {1'b0, in_data.node_b} < n_eff;
    c.n_eff = n_eff;
    c.sq = in_data.squared_length;
  end

  assign in_ready = cnt_r != 2'd2;
  assign push = in_valid && in_ready;
  assign cmd_valid = cnt_r != 2'd0;
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
    if (push) q_r[wp_r] <= c;
  end

endmodule

@@ rtl/core/kufe_sqrt.sv @@
// Iterative integer square root, one result bit settled per pass, one pass per cycle.
module kufe_sqrt
  import kufe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SqW-1:0]   sq,
  output logic             done,
  output logic [RootW-1:0] root
);

  localparam int Steps = RadW / 2;
  logic [RadW-1:0] rem_r, rem_nxt, rad_r, rad_nxt;
  logic [RootW-1:0] res_r, res_nxt;
  logic [$clog2(Steps+1)-1:0] cnt_r;
  logic busy_r;
  logic [RootW+1:0] trial, cur;

  always_comb begin
    cur = {rem_r[RootW-1:0], rad_r[RadW-1 -: 2]};
    trial = {res_r, 2'b01};
    rem_nxt = rem_r;
    res_nxt = {res_r[RootW-2:0], 1'b0};
    if (cur >= trial) begin
      rem_nxt = RadW'(cur - trial);
      res_nxt = {res_r[RootW-2:0], 1'b1};
    end else begin
      rem_nxt = RadW'(cur);
    end
    rad_nxt = {rad_r[RadW-3:0], 2'b00};
  end

  assign done = busy_r && cnt_r == '0;
  assign root = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= ($clog2(Steps+1))'(Steps);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
    if (start) begin
      rem_r <= '0;
      res_r <= '0;
      rad_r <= {1'b0, sq, 16'd0};
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      rad_r <= rad_nxt;
    end
  end

endmodule

@@ rtl/core/kufe_back.sv @@
// Back end: parent table clear sweep, root walks with compression, merge and sum.
module kufe_back
  import kufe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_WWAIT = 4'd5;
  localparam logic [3:0] S_COMP  = 4'd6;
  localparam logic [3:0] S_CWAIT = 4'd7;
  localparam logic [3:0] S_MERGE = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [NodeW-1:0] mem [MaxNodes];
  logic [NodeW-1:0] rd_data_r, rd_addr, wr_addr, wr_data;
  logic wr_en;

  logic [3:0] st_r, st_nxt;
  logic [NodeW:0] sweep_r, sweep_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic side_r, side_nxt;
  logic [NodeW-1:0] cur_r, cur_nxt, ra_r, ra_nxt, root_r, root_nxt;
  logic [CountW-1:0] comp_r, comp_nxt;
  logic [LenW-1:0] sum_r, sum_nxt;
  logic acc_r, acc_nxt;
  out_word_t obuf_r, obuf_nxt;
  logic ov_r, ov_nxt;
  logic sq_start, sq_done;
  logic [RootW-1:0] sq_root;
  logic [LenW:0] sum_add;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  kufe_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .sq(cmd_r.sq),
    .done(sq_done), .root(sq_root)
  );

  assign sum_add = {1'b0, sum_r} + (LenW+1)'(sq_root);
  assign out_valid = ov_r;
  assign out_data = obuf_r;

  always_comb begin
    st_nxt = st_r;
    sweep_nxt = sweep_r;
    cmd_nxt = cmd_r;
    side_nxt = side_r;
    cur_nxt = cur_r;
    ra_nxt = ra_r;
    root_nxt = root_r;
    comp_nxt = comp_r;
    sum_nxt = sum_r;
    acc_nxt = acc_r;
    obuf_nxt = obuf_r;
    ov_nxt = ov_r && !out_ready;
    rd_addr = cur_r;
    wr_en = 1'b0;
    wr_addr = sweep_r[NodeW-1:0];
    wr_data = sweep_r[NodeW-1:0];
    cmd_ready = 1'b0;
    sq_start = 1'b0;
    unique case (st_r)
      S_INIT: begin
        wr_en = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (NodeW+1)'(MaxNodes - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          acc_nxt = 1'b0;
          if (cmd.clear) begin
            sweep_nxt = '0;
            comp_nxt = cmd.n_eff;
            sum_nxt = '0;
            st_nxt = S_CLR;
          end else begin
            st_nxt = S_CHECK;
          end
        end
      end
      S_CLR: begin
        wr_en = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (NodeW+1)'(MaxNodes - 1)) st_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (comp_r > CountW'(1) && cmd_r.a_ok && cmd_r.b_ok) begin
          side_nxt = 1'b0;
          cur_nxt = cmd_r.node_a;
          st_nxt = S_WALK;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_WALK: st_nxt = S_WWAIT;
      S_WWAIT: begin
        if (rd_data_r == cur_r) begin
          root_nxt = cur_r;
          cur_nxt = side_r ? cmd_r.node_b : cmd_r.node_a;
          st_nxt = S_COMP;
        end else begin
          cur_nxt = rd_data_r;
          st_nxt = S_WALK;
        end
      end
      S_COMP: st_nxt = S_CWAIT;
      S_CWAIT: begin
        wr_en = 1'b1;
        wr_addr = cur_r;
        wr_data = root_r;
        if (cur_r == root_r) begin
          wr_en = 1'b0;
          if (!side_r) begin
            ra_nxt = root_r;
            side_nxt = 1'b1;
            cur_nxt = cmd_r.node_b;
            st_nxt = S_WALK;
          end else begin
            st_nxt = S_MERGE;
          end
        end else begin
          cur_nxt = rd_data_r;
          st_nxt = S_COMP;
        end
      end
      S_MERGE: begin
        if (ra_r != root_r) begin
          wr_en = 1'b1;
          wr_addr = ra_r;
          wr_data = root_r;
          comp_nxt = comp_r - 1'b1;
          acc_nxt = 1'b1;
          sq_start = 1'b1;
          st_nxt = S_SQRT;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          sum_nxt = sum_add[LenW] ? '1 : sum_add[LenW-1:0];
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          obuf_nxt.accepted = acc_r;
          obuf_nxt.components_left = comp_r;
          obuf_nxt.total_length = sum_r;
          obuf_nxt.finished = comp_r == CountW'(1);
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      sweep_r <= '0;
      comp_r <= NodeCountReset;
      sum_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sweep_r <= sweep_nxt;
      comp_r <= comp_nxt;
      sum_r <= sum_nxt;
      ov_r <= ov_nxt;
    end
    cmd_r <= cmd_nxt;
    side_r <= side_nxt;
    cur_r <= cur_nxt;
    ra_r <= ra_nxt;
    root_r <= root_nxt;
    acc_r <= acc_nxt;
    obuf_r <= obuf_nxt;
  end

endmodule
